### rtl/core/button_debounce_long_press_macros.svh
// Assertion macros used by the debouncer checker file.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Clocked assertion, suspended while reset is asserted
`define BDLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define BDLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/bdlp_pkg.sv
// Package with types and constants of the button debouncer.
package bdlp_pkg;

    localparam int TIME_W  = 16;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0] DEBOUNCE_LIM_RST  = 16'd50;
    localparam logic [TIME_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NOT_AVAILABLE = 3'd0,
        EV_IDLE          = 3'd1,
        EV_PRESSED       = 3'd2,
        EV_RELEASED      = 3'd3,
        EV_HELD          = 3'd4
    } t_event;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED       = 2'd0,
        CFG_PULL_UP       = 2'd1,
        CFG_DEBOUNCE_LIM  = 2'd2,
        CFG_LONG_PRESS_MS = 2'd3
    } t_cfg_idx;

    // Current configuration, handed from the register file to the step logic
    typedef struct packed {
        logic              enabled;
        logic              pull_up;
        logic [TIME_W-1:0] debounce_lim;
        logic [TIME_W-1:0] long_press_ms;
    } t_cfg;

endpackage

### rtl/core/bdlp_cfg_regs.sv
// Configuration register file of the button debouncer.
module bdlp_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output bdlp_pkg::t_cfg                     o_cfg
);

    bdlp_pkg::t_cfg r_cfg;
    bdlp_pkg::t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (bdlp_pkg::t_cfg_idx'(i_cfg_index))
                bdlp_pkg::CFG_ENABLED:       n_cfg.enabled       = i_cfg_wdata[0];
                bdlp_pkg::CFG_PULL_UP:       n_cfg.pull_up       = i_cfg_wdata[0];
                bdlp_pkg::CFG_DEBOUNCE_LIM:  n_cfg.debounce_lim  = i_cfg_wdata;
                bdlp_pkg::CFG_LONG_PRESS_MS: n_cfg.long_press_ms = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled       <= 1'b0;
            r_cfg.pull_up       <= 1'b0;
            r_cfg.debounce_lim  <= bdlp_pkg::DEBOUNCE_LIM_RST;
            r_cfg.long_press_ms <= bdlp_pkg::LONG_PRESS_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/bdlp_step.sv
// Debounce and long-press state with the per-poll decision logic.
module bdlp_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bdlp_pkg::t_cfg                  i_cfg,
    input  logic                            i_fire,
    input  logic [bdlp_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_raw_level,
    output bdlp_pkg::t_event                o_event_res,
    output logic                            o_held_status
);

    logic                        r_last_seen_pressed;
    logic                        r_stable_pressed;
    logic [bdlp_pkg::TIME_W-1:0] r_change_time;
    logic [bdlp_pkg::TIME_W-1:0] r_press_time;
    logic                        r_held_flag;

    logic                        n_last_seen_pressed;
    logic                        n_stable_pressed;
    logic [bdlp_pkg::TIME_W-1:0] n_change_time;
    logic [bdlp_pkg::TIME_W-1:0] n_press_time;
    logic                        n_held_flag;

    logic                        pressed;
    logic [bdlp_pkg::TIME_W-1:0] steady_age;
    logic [bdlp_pkg::TIME_W-1:0] press_age;
    bdlp_pkg::t_event            event_res;

    // Active-high level and wrapping time differences
    assign pressed    = i_raw_level ^ i_cfg.pull_up;
    assign steady_age = i_now_ms - n_change_time;
    assign press_age  = i_now_ms - r_press_time;

    // Next state and event for this poll
    always_comb begin
        n_last_seen_pressed = r_last_seen_pressed;
        n_stable_pressed    = r_stable_pressed;
        n_change_time       = r_change_time;
        n_press_time        = r_press_time;
        n_held_flag         = r_held_flag;
        event_res           = bdlp_pkg::EV_NOT_AVAILABLE;
        if (i_cfg.enabled) begin
            // a raw change restarts the steady time
            if (pressed != r_last_seen_pressed) begin
                n_change_time       = i_now_ms;
                n_last_seen_pressed = pressed;
            end
            if ((steady_age > i_cfg.debounce_lim) && (pressed != r_stable_pressed)) begin
                n_stable_pressed = pressed;
                if (pressed) begin
                    n_press_time = i_now_ms;
                    event_res    = bdlp_pkg::EV_PRESSED;
                end else begin
                    n_held_flag = 1'b0;
                    event_res   = bdlp_pkg::EV_RELEASED;
                end
            end else if (r_stable_pressed && (press_age >= i_cfg.long_press_ms)) begin
                n_held_flag = 1'b1;
                event_res   = bdlp_pkg::EV_HELD;
            end else begin
                event_res = bdlp_pkg::EV_IDLE;
            end
        end
    end

    // State advances only when a poll goes through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seen_pressed <= 1'b0;
            r_stable_pressed    <= 1'b0;
            r_change_time       <= '0;
            r_press_time        <= '0;
            r_held_flag         <= 1'b0;
        end else if (i_fire) begin
            r_last_seen_pressed <= n_last_seen_pressed;
            r_stable_pressed    <= n_stable_pressed;
            r_change_time       <= n_change_time;
            r_press_time        <= n_press_time;
            r_held_flag         <= n_held_flag;
        end
    end

    assign o_event_res   = event_res;
    assign o_held_status = n_held_flag;

endmodule

### rtl/core/button_debounce_long_press.sv
// Top level of the button debouncer with long-press detection.
//
// Usage:
//   Poll channel: i_in_valid / o_in_ready carry one poll (i_now_ms, a wrapping
//   millisecond timestamp, and i_raw_level, the pin level) per transfer.
//   Result channel: o_out_valid / i_out_ready carry one result per poll:
//   o_event_res (not available, idle, pressed, released, held) and
//   o_held_status (held flag after that poll).
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
//   (0 enabled, 1 pull-up, 2 debounce time, 3 long-press time).
// Timing:
//   A transferred poll is captured in the poll register and moves into the
//   result register when that is free or being drained.
//   One poll per cycle is taken in steady flow, while the receiver is ready.
//   While the receiver stalls, the result register holds its item and the
//   poll register still takes one more poll; then o_in_ready drops.
// Reset:
//   Synchronous, active low. Both stages empty, the button state reads
//   released, the block is disabled with 50 ms debounce and 1000 ms
//   long-press times.
module button_debounce_long_press (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bdlp_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_raw_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bdlp_pkg::EVENT_W-1:0]    o_event_res,
    output logic                            o_held_status
);

    bdlp_pkg::t_cfg              cfg;
    logic                        r_in_valid;
    logic [bdlp_pkg::TIME_W-1:0] r_in_now_ms;
    logic                        r_in_raw_level;
    logic                        r_out_valid;
    bdlp_pkg::t_event            r_out_event;
    logic                        r_out_held;
    logic                        advance;
    logic                        in_xfer;
    bdlp_pkg::t_event            step_event;
    logic                        step_held;

    bdlp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Poll moves into the result register when that is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Poll register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_now_ms    <= i_now_ms;
            r_in_raw_level <= i_raw_level;
        end
    end

    bdlp_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_fire        (advance),
        .i_now_ms      (r_in_now_ms),
        .i_raw_level   (r_in_raw_level),
        .o_event_res   (step_event),
        .o_held_status (step_held)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= step_event;
            r_out_held  <= step_held;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out_event;
    assign o_held_status = r_out_held;

endmodule

### rtl/core/bdlp_checker.sv
// Port-level checker of the button debouncer and its bind.
`include "button_debounce_long_press_macros.svh"

module bdlp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [bdlp_pkg::EVENT_W-1:0]    o_event_res,
    input logic                            o_held_status
);

    // stalled result holds
    `BDLP_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_event_res) && $stable(o_held_status)), "stalled result changed")

    // held event always comes with the held flag set
    `BDLP_ASSERT(a_held_flag, (o_out_valid && (o_event_res == bdlp_pkg::EV_HELD)) |-> o_held_status, "held event without held flag")

    // release clears the held flag
    `BDLP_ASSERT(a_release_clears, (o_out_valid && (o_event_res == bdlp_pkg::EV_RELEASED)) |-> !o_held_status, "held flag set after release")

    // empty result side never blocks a poll
    `BDLP_ASSERT(a_ready_when_empty, !o_out_valid |-> o_in_ready, "poll blocked with empty result register")

    // no result straight after reset
    `BDLP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_event_res   (o_event_res),
    .o_held_status (o_held_status)
);
